[hw/rtl/gfnv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfnv_pkg
// shared codes and types for the gf2 basis / null-vector block
// ----------------------------------------------------------------------------
package gfnv_pkg;

  // action codes carried by an input item
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_SOLVE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // reset value of the column count register
  localparam logic [5:0] NUM_COLUMNS_RST = 6'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FWD,
    ST_BWD,
    ST_DONE
  } state_t;

  // per-cell row control from the sequencer
  typedef struct packed {
    logic row_valid;
    logic wr_en;
  } row_ctl_t;

endpackage

[hw/rtl/gfnv_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfnv_cell
// one basis row with its one-hot pivot; forward reduce stage and backward
// back-substitution stage, each registered toward its neighbor
// ----------------------------------------------------------------------------
module gfnv_cell #(
  parameter int VB = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gfnv_pkg::row_ctl_t  row_ctl,
  input  logic [VB-1:0]       wr_row,
  input  logic [VB-1:0]       colmask,
  input  logic                fwd_vld_in,
  input  logic [VB-1:0]       fwd_rem_in,
  input  logic [VB-1:0]       fwd_used_in,
  output logic                fwd_vld_out,
  output logic [VB-1:0]       fwd_rem_out,
  output logic [VB-1:0]       fwd_used_out,
  input  logic                bwd_vld_in,
  input  logic [VB-1:0]       bwd_s_in,
  output logic                bwd_vld_out,
  output logic [VB-1:0]       bwd_s_out
);

  logic [VB-1:0] row_r;
  logic [VB-1:0] piv_r;

  logic          fwd_vld_r;
  logic [VB-1:0] fwd_rem_r, fwd_rem_nxt;
  logic [VB-1:0] fwd_used_r, fwd_used_nxt;
  logic          bwd_vld_r;
  logic [VB-1:0] bwd_s_r, bwd_s_nxt;

  logic          hit;
  logic          in_cols;
  logic [VB-1:0] above;
  logic          par;

  always_comb begin
    // row takes part in solve only if its pivot lies below the column count
    in_cols      = row_ctl.row_valid && (|(piv_r & colmask));
    hit          = row_ctl.row_valid && (|(fwd_rem_in & piv_r));
    fwd_rem_nxt  = hit ? (fwd_rem_in ^ row_r) : fwd_rem_in;
    fwd_used_nxt = fwd_used_in | (in_cols ? piv_r : '0);
    above        = ~(piv_r | (piv_r - VB'(1)));
    par          = ^(row_r & bwd_s_in & above & colmask);
    bwd_s_nxt    = bwd_s_in | ((in_cols && par) ? piv_r : '0);
  end

  always_ff @(posedge clk) begin
    if (row_ctl.wr_en) begin
      row_r <= wr_row;
      piv_r <= wr_row & (~wr_row + VB'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
      bwd_vld_r <= 1'b0;
    end else begin
      fwd_vld_r <= fwd_vld_in;
      bwd_vld_r <= bwd_vld_in;
    end
  end

  always_ff @(posedge clk) begin
    fwd_rem_r  <= fwd_rem_nxt;
    fwd_used_r <= fwd_used_nxt;
    bwd_s_r    <= bwd_s_nxt;
  end

  assign fwd_vld_out  = fwd_vld_r;
  assign fwd_rem_out  = fwd_rem_r;
  assign fwd_used_out = fwd_used_r;
  assign bwd_vld_out  = bwd_vld_r;
  assign bwd_s_out    = bwd_s_r;

endmodule

[hw/rtl/gf2_incremental_basis_nullvector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_incremental_basis_nullvector
// incremental gf2 row basis with a null-space vector solver, built as a
// chain of VB row cells walked forward (reduce) and backward (solve)
// ----------------------------------------------------------------------------
// add walks the chain forward; solve walks it forward and, when a free column
//   exists, backward; clear and unused code go straight to the result
// one item at a time; a single token walks the VB-cell chain once forward and,
//   for solve, once backward; a new item is taken only after the result is handed over
// reset: rank and chain tokens cleared, column count 8; row storage is not
//   cleared since only rows below the rank are ever used
module gf2_incremental_basis_nullvector #(
  parameter int VB = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_num_columns,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_vector_bits,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_added,
  output logic [5:0]  out_basis_rank,
  output logic [31:0] out_null_vector,
  output logic        out_free_found
);

  localparam int CW  = $clog2(VB + 1);
  localparam int LIM = (VB < 32) ? VB : 32;

  gfnv_pkg::state_t state_r, state_nxt;

  logic [5:0]    ncol_r;
  logic [CW-1:0] row_count_r, row_count_nxt;
  logic          solve_r, solve_nxt;

  // chain launch registers
  logic          fwd_go_r, fwd_go_nxt;
  logic [VB-1:0] fwd_rem0_r, fwd_rem0_nxt;
  logic          bwd_go_r, bwd_go_nxt;
  logic [VB-1:0] bwd_s0_r, bwd_s0_nxt;

  // pending result of the item in flight
  logic          res_added_r, res_added_nxt;
  logic [31:0]   res_null_r, res_null_nxt;
  logic          res_ff_r, res_ff_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_added_r, out_added_nxt;
  logic [5:0]    out_rank_r, out_rank_nxt;
  logic [31:0]   out_null_r, out_null_nxt;
  logic          out_ff_r, out_ff_nxt;

  // chain wiring: fwd index i feeds cell i, bwd index i+1 feeds cell i
  logic [VB:0]   fwd_vld;
  logic [VB-1:0] fwd_rem  [0:VB];
  logic [VB-1:0] fwd_used [0:VB];
  logic [VB:0]   bwd_vld;
  logic [VB-1:0] bwd_s    [0:VB];

  logic          wr_en;
  logic [VB-1:0] colmask;
  logic [5:0]    nb;
  logic [VB-1:0] free_oh;
  logic [6:0]    rc7;
  logic [5:0]    rank_sat;

  assign cfg_ready = 1'b1;

  // effective column count, saturated to the row width and to 32
  assign nb = (ncol_r > 6'(LIM)) ? 6'(LIM) : ncol_r;

  always_comb begin
    for (int j = 0; j < VB; j++) begin
      colmask[j] = (j < int'(nb));
    end
  end

  // lowest column that no counted pivot claims
  assign free_oh = ~fwd_used[VB] & (fwd_used[VB] + VB'(1));

  assign rc7      = 7'(row_count_r);
  assign rank_sat = (rc7 > 7'd63) ? 6'd63 : rc7[5:0];

  assign fwd_vld[0]  = fwd_go_r;
  assign fwd_rem[0]  = fwd_rem0_r;
  assign fwd_used[0] = '0;
  assign bwd_vld[VB] = bwd_go_r;
  assign bwd_s[VB]   = bwd_s0_r;

  // row cells, oldest row in cell 0
  for (genvar i = 0; i < VB; i++) begin : g_cell
    gfnv_pkg::row_ctl_t row_ctl;

    assign row_ctl.row_valid = CW'(i) < row_count_r;
    assign row_ctl.wr_en     = wr_en && (row_count_r == CW'(i));

    gfnv_cell #(.VB(VB)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .row_ctl      (row_ctl),
      .wr_row       (fwd_rem[VB]),
      .colmask      (colmask),
      .fwd_vld_in   (fwd_vld[i]),
      .fwd_rem_in   (fwd_rem[i]),
      .fwd_used_in  (fwd_used[i]),
      .fwd_vld_out  (fwd_vld[i+1]),
      .fwd_rem_out  (fwd_rem[i+1]),
      .fwd_used_out (fwd_used[i+1]),
      .bwd_vld_in   (bwd_vld[i+1]),
      .bwd_s_in     (bwd_s[i+1]),
      .bwd_vld_out  (bwd_vld[i]),
      .bwd_s_out    (bwd_s[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    row_count_nxt = row_count_r;
    solve_nxt     = solve_r;
    fwd_go_nxt    = 1'b0;
    fwd_rem0_nxt  = fwd_rem0_r;
    bwd_go_nxt    = 1'b0;
    bwd_s0_nxt    = bwd_s0_r;
    res_added_nxt = res_added_r;
    res_null_nxt  = res_null_r;
    res_ff_nxt    = res_ff_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_added_nxt = out_added_r;
    out_rank_nxt  = out_rank_r;
    out_null_nxt  = out_null_r;
    out_ff_nxt    = out_ff_r;
    wr_en         = 1'b0;
    in_ready      = (state_r == gfnv_pkg::ST_IDLE);

    case (state_r)
      gfnv_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_added_nxt = 1'b0;
          res_null_nxt  = '0;
          res_ff_nxt    = 1'b0;
          case (in_action)
            gfnv_pkg::ACT_ADD: begin
              fwd_go_nxt   = 1'b1;
              fwd_rem0_nxt = VB'(in_vector_bits);
              solve_nxt    = 1'b0;
              state_nxt    = gfnv_pkg::ST_FWD;
            end
            gfnv_pkg::ACT_SOLVE: begin
              fwd_go_nxt = 1'b1;
              solve_nxt  = 1'b1;
              state_nxt  = gfnv_pkg::ST_FWD;
            end
            gfnv_pkg::ACT_CLEAR: begin
              row_count_nxt = '0;
              state_nxt     = gfnv_pkg::ST_DONE;
            end
            default: begin
              // unused code: nothing changes
              state_nxt = gfnv_pkg::ST_DONE;
            end
          endcase
        end
      end
      gfnv_pkg::ST_FWD: begin
        if (fwd_vld[VB]) begin
          if (!solve_r) begin
            // fully reduced remainder; store it if independent and room left
            if ((fwd_rem[VB] != '0) && (row_count_r < CW'(VB))) begin
              wr_en         = 1'b1;
              row_count_nxt = row_count_r + CW'(1);
              res_added_nxt = 1'b1;
            end
            state_nxt = gfnv_pkg::ST_DONE;
          end else if (|(free_oh & colmask)) begin
            bwd_go_nxt = 1'b1;
            bwd_s0_nxt = free_oh & colmask;
            state_nxt  = gfnv_pkg::ST_BWD;
          end else begin
            state_nxt = gfnv_pkg::ST_DONE;
          end
        end
      end
      gfnv_pkg::ST_BWD: begin
        if (bwd_vld[0]) begin
          res_null_nxt = 32'(bwd_s[0]);
          res_ff_nxt   = 1'b1;
          state_nxt    = gfnv_pkg::ST_DONE;
        end
      end
      gfnv_pkg::ST_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_added_nxt = res_added_r;
          out_rank_nxt  = rank_sat;
          out_null_nxt  = res_null_r;
          out_ff_nxt    = res_ff_r;
          state_nxt     = gfnv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gfnv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gfnv_pkg::ST_IDLE;
      row_count_r <= '0;
      ncol_r      <= gfnv_pkg::NUM_COLUMNS_RST;
      fwd_go_r    <= 1'b0;
      bwd_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_count_r <= row_count_nxt;
      fwd_go_r    <= fwd_go_nxt;
      bwd_go_r    <= bwd_go_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        ncol_r <= cfg_num_columns;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    solve_r     <= solve_nxt;
    fwd_rem0_r  <= fwd_rem0_nxt;
    bwd_s0_r    <= bwd_s0_nxt;
    res_added_r <= res_added_nxt;
    res_null_r  <= res_null_nxt;
    res_ff_r    <= res_ff_nxt;
    out_added_r <= out_added_nxt;
    out_rank_r  <= out_rank_nxt;
    out_null_r  <= out_null_nxt;
    out_ff_r    <= out_ff_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_added       = out_added_r;
  assign out_basis_rank  = out_rank_r;
  assign out_null_vector = out_null_r;
  assign out_free_found  = out_ff_r;

`ifndef SYNTHESIS
  // rank never exceeds the number of cells
  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_count_r <= CW'(VB))
    else $error("rank above cell count");

  // at most one token travels each direction of the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(fwd_vld) && $onehot0(bwd_vld))
    else $error("more than one token in the chain");

  // an item is taken only with the chain empty
  a_idle_chain: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (fwd_vld == '0) && (bwd_vld == '0))
    else $error("item taken while chain busy");

  // storing a row raises the rank by one
  a_store_rank: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> row_count_r == $past(row_count_r) + CW'(1))
    else $error("row stored without rank increment");
`endif

endmodule
